/* rtl/ca80_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ca80_pkg;

    localparam int unsigned KIND_W = 5;
    localparam int unsigned BYTE_W = 8;

    // Operation codes carried on the input tuser.
    typedef enum logic [KIND_W-1:0] {
        K_ADD  = 5'd0,
        K_ADC  = 5'd1,
        K_SUB  = 5'd2,
        K_SBB  = 5'd3,
        K_ANA  = 5'd4,
        K_XRA  = 5'd5,
        K_ORA  = 5'd6,
        K_CMP  = 5'd7,
        K_INR  = 5'd8,
        K_DCR  = 5'd9,
        K_RLC  = 5'd10,
        K_RRC  = 5'd11,
        K_RAL  = 5'd12,
        K_RAR  = 5'd13,
        K_DAA  = 5'd14,
        K_CMA  = 5'd15,
        K_STC  = 5'd16,
        K_CMC  = 5'd17,
        K_LDA  = 5'd18,
        K_LDF  = 5'd19
    } t_kind;

    // Decimal adjust constants.
    localparam logic [3:0] DAA_LIMIT = 4'h9;
    localparam logic [3:0] DAA_STEP  = 4'h6;

    // Flag byte bit positions.
    localparam int unsigned PSW_S  = 7;
    localparam int unsigned PSW_Z  = 6;
    localparam int unsigned PSW_AC = 4;
    localparam int unsigned PSW_P  = 2;
    localparam int unsigned PSW_C  = 0;
    localparam logic [BYTE_W-1:0] PSW_FIXED = 8'h02;

    typedef struct packed {
        logic s;
        logic z;
        logic ac;
        logic p;
        logic c;
    } t_flags;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] operand;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] acc;
        t_flags            flags;
        logic [BYTE_W-1:0] result_value;
    } t_alu_res;

endpackage

`default_nettype wire

/* rtl/ca80_in_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module ca80_in_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire ca80_pkg::t_item i_item,
    output logic                 o_valid,
    input  wire logic            i_advance,
    output ca80_pkg::t_item      o_item
);

    logic            r_valid;
    ca80_pkg::t_item r_item;

    // Take a new operation when empty or when the held one moves on.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* rtl/ca80_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

module ca80_alu (
    input  wire ca80_pkg::t_item  i_item,
    input  wire logic [7:0]       i_acc,
    input  wire ca80_pkg::t_flags i_flags,
    output ca80_pkg::t_alu_res    o_res
);

    ca80_pkg::t_kind kind;
    logic [7:0]      opv;
    logic            is_sub;
    logic [7:0]      b_in;
    logic            cin;
    logic [8:0]      sum;
    logic [4:0]      half;
    logic            add_c;
    logic [7:0]      inr_v;
    logic [7:0]      dcr_v;
    logic [3:0]      lo;
    logic [3:0]      hi;
    logic            daa_lo;
    logic            daa_hi;
    logic [7:0]      corr;
    logic [4:0]      daa_half;
    logic [7:0]      daa_v;
    logic [7:0]      acc_n;
    logic [7:0]      szp_src;
    logic            szp_upd;
    ca80_pkg::t_flags fl_n;
    logic [7:0]      rv;

    assign kind = ca80_pkg::t_kind'(i_item.kind);
    assign opv  = i_item.operand;

    // Shared adder: subtract runs as A + ~B + not-borrow.
    assign is_sub = (kind == ca80_pkg::K_SUB) || (kind == ca80_pkg::K_SBB)
                 || (kind == ca80_pkg::K_CMP);
    assign b_in   = is_sub ? ~opv : opv;
    always_comb begin
        case (kind)
            ca80_pkg::K_ADC: cin = i_flags.c;
            ca80_pkg::K_SUB: cin = 1'b1;
            ca80_pkg::K_CMP: cin = 1'b1;
            ca80_pkg::K_SBB: cin = !i_flags.c;
            default:         cin = 1'b0;
        endcase
    end
    assign sum   = {1'b0, i_acc} + {1'b0, b_in} + {8'd0, cin};
    assign half  = {1'b0, i_acc[3:0]} + {1'b0, b_in[3:0]} + {4'd0, cin};
    assign add_c = is_sub ? !sum[8] : sum[8];

    assign inr_v = opv + 8'd1;
    assign dcr_v = opv - 8'd1;

    // Decimal adjust.
    assign lo     = i_acc[3:0];
    assign hi     = i_acc[7:4];
    assign daa_lo = (lo > ca80_pkg::DAA_LIMIT) || i_flags.ac;
    assign daa_hi = (hi > ca80_pkg::DAA_LIMIT) || i_flags.c
                 || ((hi >= ca80_pkg::DAA_LIMIT) && (lo > ca80_pkg::DAA_LIMIT));
    assign corr   = {(daa_hi ? ca80_pkg::DAA_STEP : 4'h0),
                     (daa_lo ? ca80_pkg::DAA_STEP : 4'h0)};
    assign daa_half = {1'b0, lo} + {1'b0, corr[3:0]};
    assign daa_v    = i_acc + corr;

    always_comb begin
        acc_n   = i_acc;
        fl_n    = i_flags;
        szp_src = i_acc;
        szp_upd = 1'b0;
        rv      = 8'd0;
        case (kind)
            ca80_pkg::K_ADD, ca80_pkg::K_ADC, ca80_pkg::K_SUB, ca80_pkg::K_SBB: begin
                acc_n   = sum[7:0];
                fl_n.c  = add_c;
                fl_n.ac = half[4];
                szp_src = sum[7:0];
                szp_upd = 1'b1;
            end
            ca80_pkg::K_CMP: begin
                fl_n.c  = add_c;
                fl_n.ac = half[4];
                szp_src = sum[7:0];
                szp_upd = 1'b1;
            end
            ca80_pkg::K_ANA, ca80_pkg::K_XRA, ca80_pkg::K_ORA: begin
                case (kind)
                    ca80_pkg::K_ANA: acc_n = i_acc & opv;
                    ca80_pkg::K_XRA: acc_n = i_acc ^ opv;
                    default:         acc_n = i_acc | opv;
                endcase
                fl_n.c  = 1'b0;
                fl_n.ac = 1'b0;
                szp_src = acc_n;
                szp_upd = 1'b1;
            end
            ca80_pkg::K_INR: begin
                fl_n.ac = (inr_v[3:0] == 4'h0);
                szp_src = inr_v;
                szp_upd = 1'b1;
            end
            ca80_pkg::K_DCR: begin
                fl_n.ac = (opv[3:0] != 4'h0);
                szp_src = dcr_v;
                szp_upd = 1'b1;
            end
            ca80_pkg::K_RLC: begin
                fl_n.c = i_acc[7];
                acc_n  = {i_acc[6:0], i_acc[7]};
            end
            ca80_pkg::K_RRC: begin
                fl_n.c = i_acc[0];
                acc_n  = {i_acc[0], i_acc[7:1]};
            end
            ca80_pkg::K_RAL: begin
                fl_n.c = i_acc[7];
                acc_n  = {i_acc[6:0], i_flags.c};
            end
            ca80_pkg::K_RAR: begin
                fl_n.c = i_acc[0];
                acc_n  = {i_flags.c, i_acc[7:1]};
            end
            ca80_pkg::K_DAA: begin
                acc_n   = daa_v;
                fl_n.ac = daa_half[4];
                fl_n.c  = i_flags.c || daa_hi;
                szp_src = daa_v;
                szp_upd = 1'b1;
            end
            ca80_pkg::K_CMA: acc_n = ~i_acc;
            ca80_pkg::K_STC: fl_n.c = 1'b1;
            ca80_pkg::K_CMC: fl_n.c = !i_flags.c;
            ca80_pkg::K_LDA: acc_n = opv;
            ca80_pkg::K_LDF: begin
                fl_n.s  = opv[ca80_pkg::PSW_S];
                fl_n.z  = opv[ca80_pkg::PSW_Z];
                fl_n.ac = opv[ca80_pkg::PSW_AC];
                fl_n.p  = opv[ca80_pkg::PSW_P];
                fl_n.c  = opv[ca80_pkg::PSW_C];
            end
            default: begin
            end
        endcase
        if (szp_upd) begin
            fl_n.s = szp_src[7];
            fl_n.z = (szp_src == 8'd0);
            fl_n.p = ~^szp_src;
        end
        case (kind)
            ca80_pkg::K_INR: rv = inr_v;
            ca80_pkg::K_DCR: rv = dcr_v;
            default:         rv = acc_n;
        endcase
    end

    assign o_res.acc          = acc_n;
    assign o_res.flags        = fl_n;
    assign o_res.result_value = rv;

endmodule

`default_nettype wire

/* rtl/ca80_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module ca80_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_advance,
    input  wire ca80_pkg::t_alu_res i_res,
    output logic [7:0]             o_acc,
    output ca80_pkg::t_flags       o_flags,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [23:0]            o_data
);

    logic [7:0]       r_acc;
    ca80_pkg::t_flags r_flags;
    logic             r_valid;
    logic [7:0]       r_acc_out;
    logic [7:0]       r_psw;
    logic [7:0]       r_rv;
    logic             load;
    logic [7:0]       psw_n;

    assign o_advance = i_valid && (!r_valid || i_ready);
    assign load      = o_advance;

    always_comb begin
        psw_n                   = ca80_pkg::PSW_FIXED;
        psw_n[ca80_pkg::PSW_S]  = i_res.flags.s;
        psw_n[ca80_pkg::PSW_Z]  = i_res.flags.z;
        psw_n[ca80_pkg::PSW_AC] = i_res.flags.ac;
        psw_n[ca80_pkg::PSW_P]  = i_res.flags.p;
        psw_n[ca80_pkg::PSW_C]  = i_res.flags.c;
    end

    // Architectural state commits together with the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 8'd0;
            r_flags <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_acc   <= i_res.acc;
                r_flags <= i_res.flags;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_acc_out <= i_res.acc;
            r_psw     <= psw_n;
            r_rv      <= i_res.result_value;
        end
    end

    assign o_acc   = r_acc;
    assign o_flags = r_flags;
    assign o_valid = r_valid;
    assign o_data  = {r_rv, r_psw, r_acc_out};

endmodule

`default_nettype wire

/* rtl/cpu8080_alu_flags_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// The result shows on the master side from the result register, loaded from the input
// register through the ALU once the result register is free or being taken.
// Throughput: one operation per clock while the master side takes results; a waiting
// result lets one more operation into the input register, then tready drops.
// The ALU sits between the input and result registers; accumulator and flags commit
// on the edge that loads the result. Reset (synchronous, active low) clears the
// accumulator, all flags and both valids.
module cpu8080_alu_flags_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] operand
    input  wire logic [4:0]  i_s_axis_tuser,   // [4:0] kind
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata    // [7:0] acc_out, [15:8] psw_flags,
                                               // [23:16] result_value
);

    ca80_pkg::t_item    in_item;
    ca80_pkg::t_item    stg_item;
    logic               stg_valid;
    logic               advance;
    logic [7:0]         acc;
    ca80_pkg::t_flags   flags;
    ca80_pkg::t_alu_res alu_res;

    assign in_item.kind    = i_s_axis_tuser;
    assign in_item.operand = i_s_axis_tdata;

    // Input register: hold one operation until the ALU result can be stored.
    ca80_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (in_item),
        .o_valid   (stg_valid),
        .i_advance (advance),
        .o_item    (stg_item)
    );

    // Single-pass ALU: adder, logic, rotates, DAA and flag build.
    ca80_alu u_alu (
        .i_item  (stg_item),
        .i_acc   (acc),
        .i_flags (flags),
        .o_res   (alu_res)
    );

    // Result register plus accumulator and flag state; a back-to-back
    // operation sees the state committed on the previous edge.
    ca80_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stg_valid),
        .o_advance (advance),
        .i_res     (alu_res),
        .o_acc     (acc),
        .o_flags   (flags),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata)
    );

endmodule

`default_nettype wire
